// File: design/simple_polygon_vertex_entry_core_assert.svh
// Assertion macros used by the checker of this block.
`ifndef SIMPLE_POLYGON_VERTEX_ENTRY_CORE_ASSERT_SVH
`define SIMPLE_POLYGON_VERTEX_ENTRY_CORE_ASSERT_SVH

// Consequence must hold in the same cycle as the antecedent.
`define SPVE_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// Consequence must hold in the cycle after the antecedent.
`define SPVE_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/spve_pkg.sv
package spve_pkg;

	localparam int MAX_VERTICES = 64;
	localparam int MIN_POLY     = 3;
	localparam int COORD_W      = 10;
	localparam int DIFF_W       = COORD_W + 1;
	localparam int PROD_W       = 2 * DIFF_W + 1;
	localparam int VIDX_W       = $clog2(MAX_VERTICES);
	localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
	localparam int OP_W         = 2;
	localparam int STATUS_W     = 3;
	localparam int VTX_W        = 2 * COORD_W;

	localparam logic [COORD_W-1:0] WIN_H_RESET = COORD_W'(800);

	typedef enum logic [OP_W-1:0] {
		OP_ADD   = 2'd0,
		OP_CLOSE = 2'd1,
		OP_CLEAR = 2'd2
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK     = 3'd0,
		ST_CROSS  = 3'd1,
		ST_FEW    = 3'd2,
		ST_FULL   = 3'd3,
		ST_CLOSED = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECIDE,
		S_GET_P1,
		S_GET_P2,
		S_FETCH,
		S_DET,
		S_NUM_A,
		S_NUM_B,
		S_CHECK,
		S_PUT
	} state_t;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
	} vtx_t;

	typedef struct packed {
		logic              we;
		logic [VIDX_W-1:0] waddr;
		vtx_t              wdata;
		logic              re;
		logic [VIDX_W-1:0] raddr;
	} ram_req_t;

	// Operands of the shared cross product a*b - c*e
	typedef struct packed {
		logic signed [DIFF_W-1:0] a;
		logic signed [DIFF_W-1:0] b;
		logic signed [DIFF_W-1:0] c;
		logic signed [DIFF_W-1:0] e;
	} xp_op_t;

endpackage

// File: design/spve_ram.sv
module spve_ram #(
	parameter int WIDTH = 20,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: design/spve_xprod.sv
module spve_xprod (
	input  spve_pkg::xp_op_t                   xp_op,
	output logic signed [spve_pkg::PROD_W-1:0] xp_res
);

	import spve_pkg::*;

	logic signed [2*DIFF_W-1:0] prod_ab;
	logic signed [2*DIFF_W-1:0] prod_ce;

	assign prod_ab = xp_op.a * xp_op.b;
	assign prod_ce = xp_op.c * xp_op.e;
	assign xp_res  = {prod_ab[2*DIFF_W-1], prod_ab} - {prod_ce[2*DIFF_W-1], prod_ce};

endmodule

// File: design/spve_ctrl.sv
module spve_ctrl (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [spve_pkg::OP_W-1:0]           op,
	input  logic [spve_pkg::COORD_W-1:0]        point_x,
	input  logic [spve_pkg::COORD_W-1:0]        point_y,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [spve_pkg::STATUS_W-1:0]       status,
	output logic [spve_pkg::CNT_W-1:0]          vertex_count,
	output logic                                is_closed,
	input  logic [spve_pkg::COORD_W-1:0]        win_h,
	output logic                                idle,
	output spve_pkg::ram_req_t                  ram_req,
	input  spve_pkg::vtx_t                      ram_rdata,
	output spve_pkg::xp_op_t                    xp_op,
	input  logic signed [spve_pkg::PROD_W-1:0]  xp_res
);

	import spve_pkg::*;

	function automatic logic signed [DIFF_W-1:0] coord_diff(
		input logic [COORD_W-1:0] a,
		input logic [COORD_W-1:0] b
	);
		return $signed({1'b0, a}) - $signed({1'b0, b});
	endfunction

	// n strictly between 0 and d, either sign of d
	function automatic logic strictly_in(
		input logic signed [PROD_W-1:0] n,
		input logic signed [PROD_W-1:0] d
	);
		if (d > 0) begin
			return (n > 0) && (n < d);
		end
		return (n < 0) && (n > d);
	endfunction

	state_t state_q, state_d;
	logic [CNT_W-1:0]  count_q;
	logic              closed_q;
	logic [VIDX_W-1:0] k_q;
	logic              out_valid_q;

	op_t                      op_q;
	logic [COORD_W-1:0]       px_q, fy_q;
	logic [COORD_W-1:0]       p1x_q, p1y_q;
	logic [COORD_W-1:0]       pvx_q, pvy_q;
	logic signed [DIFF_W-1:0] dx12_q, dy12_q, dx34_q, dy34_q, ax_q, by_q;
	logic signed [PROD_W-1:0] d_q, na_q, nb_q;
	status_t                  stat_q, stat_d;
	status_t                  status_q;
	logic [CNT_W-1:0]         vcount_q;
	logic                     oclosed_q;

	logic cnt_inc, poly_clr, poly_close, k_clr, k_one, k_inc, stat_ld, out_ld;
	logic hit, last_edge;
	logic [CNT_W-1:0] last_idx;
	logic [COORD_W:0] fy_full;
	logic [COORD_W-1:0] fy;

	assign last_idx  = count_q - CNT_W'(1);
	assign last_edge = ({1'b0, k_q} == last_idx);
	assign hit       = (d_q != '0) && strictly_in(na_q, d_q) && strictly_in(nb_q, d_q);
	assign fy_full   = {1'b0, win_h} - {1'b0, point_y};
	assign fy        = fy_full[COORD_W] ? '0 : fy_full[COORD_W-1:0];

	assign idle         = (state_q == S_IDLE);
	assign in_stall     = !idle;
	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign vertex_count = vcount_q;
	assign is_closed    = oclosed_q;

	always_comb begin
		state_d       = state_q;
		cnt_inc       = 1'b0;
		poly_clr      = 1'b0;
		poly_close    = 1'b0;
		k_clr         = 1'b0;
		k_one         = 1'b0;
		k_inc         = 1'b0;
		stat_ld       = 1'b0;
		stat_d        = ST_OK;
		out_ld        = 1'b0;
		ram_req       = '0;
		ram_req.waddr = count_q[VIDX_W-1:0];
		ram_req.wdata = '{x: px_q, y: fy_q};
		xp_op         = '{a: dx34_q, b: dy12_q, c: dx12_q, e: dy34_q};
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				k_clr = 1'b1;
				case (op_q)
					OP_ADD: begin
						if (closed_q) begin
							stat_ld = 1'b1;
							stat_d  = ST_CLOSED;
							state_d = S_PUT;
						end else if (count_q >= CNT_W'(MAX_VERTICES)) begin
							stat_ld = 1'b1;
							stat_d  = ST_FULL;
							state_d = S_PUT;
						end else if (count_q < CNT_W'(MIN_POLY)) begin
							ram_req.we = 1'b1;
							cnt_inc    = 1'b1;
							stat_ld    = 1'b1;
							state_d    = S_PUT;
						end else begin
							ram_req.re    = 1'b1;
							ram_req.raddr = last_idx[VIDX_W-1:0];
							state_d       = S_GET_P1;
						end
					end
					OP_CLOSE: begin
						if (count_q < CNT_W'(MIN_POLY)) begin
							stat_ld = 1'b1;
							stat_d  = ST_FEW;
							state_d = S_PUT;
						end else begin
							ram_req.re    = 1'b1;
							ram_req.raddr = last_idx[VIDX_W-1:0];
							state_d       = S_GET_P1;
						end
					end
					OP_CLEAR: begin
						poly_clr = 1'b1;
						stat_ld  = 1'b1;
						state_d  = S_PUT;
					end
					default: begin
						stat_ld = 1'b1;
						state_d = S_PUT;
					end
				endcase
			end
			S_GET_P1: begin
				ram_req.re    = 1'b1;
				ram_req.raddr = '0;
				state_d       = (op_q == OP_CLOSE) ? S_GET_P2 : S_FETCH;
			end
			S_GET_P2: begin
				// first vertex doubles as the start of the first stored edge
				ram_req.re    = 1'b1;
				ram_req.raddr = VIDX_W'(1);
				k_one         = 1'b1;
				state_d       = S_FETCH;
			end
			S_FETCH: begin
				if (k_q == '0) begin
					ram_req.re    = 1'b1;
					ram_req.raddr = VIDX_W'(1);
					k_one         = 1'b1;
				end else begin
					state_d = S_DET;
				end
			end
			S_DET: begin
				state_d = S_NUM_A;
			end
			S_NUM_A: begin
				xp_op   = '{a: dx34_q, b: by_q, c: ax_q, e: dy34_q};
				state_d = S_NUM_B;
			end
			S_NUM_B: begin
				xp_op   = '{a: dx12_q, b: by_q, c: ax_q, e: dy12_q};
				state_d = S_CHECK;
			end
			S_CHECK: begin
				if (hit) begin
					stat_ld = 1'b1;
					stat_d  = ST_CROSS;
					state_d = S_PUT;
				end else if (last_edge) begin
					if (op_q == OP_ADD) begin
						ram_req.we = 1'b1;
						cnt_inc    = 1'b1;
					end else begin
						poly_close = 1'b1;
					end
					stat_ld = 1'b1;
					state_d = S_PUT;
				end else begin
					ram_req.re    = 1'b1;
					ram_req.raddr = k_q + VIDX_W'(1);
					k_inc         = 1'b1;
					state_d       = S_FETCH;
				end
			end
			S_PUT: begin
				// hold until the output word is free
				if (!out_valid_q || !out_stall) begin
					out_ld  = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			closed_q    <= 1'b0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (poly_clr) begin
				count_q  <= '0;
				closed_q <= 1'b0;
			end else begin
				if (cnt_inc) begin
					count_q <= count_q + CNT_W'(1);
				end
				if (poly_close) begin
					closed_q <= 1'b1;
				end
			end
			if (k_clr) begin
				k_q <= '0;
			end else if (k_one) begin
				k_q <= VIDX_W'(1);
			end else if (k_inc) begin
				k_q <= k_q + VIDX_W'(1);
			end
			if (out_ld) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					op_q <= op_t'(op);
					px_q <= point_x;
					fy_q <= fy;
				end
			end
			S_GET_P1: begin
				p1x_q  <= ram_rdata.x;
				p1y_q  <= ram_rdata.y;
				dx12_q <= coord_diff(px_q, ram_rdata.x);
				dy12_q <= coord_diff(fy_q, ram_rdata.y);
			end
			S_GET_P2: begin
				dx12_q <= coord_diff(ram_rdata.x, p1x_q);
				dy12_q <= coord_diff(ram_rdata.y, p1y_q);
				pvx_q  <= ram_rdata.x;
				pvy_q  <= ram_rdata.y;
			end
			S_FETCH: begin
				if (k_q != '0) begin
					dx34_q <= coord_diff(ram_rdata.x, pvx_q);
					dy34_q <= coord_diff(ram_rdata.y, pvy_q);
					ax_q   <= coord_diff(pvx_q, p1x_q);
					by_q   <= coord_diff(pvy_q, p1y_q);
				end
				pvx_q <= ram_rdata.x;
				pvy_q <= ram_rdata.y;
			end
			S_DET: begin
				d_q <= xp_res;
			end
			S_NUM_A: begin
				na_q <= xp_res;
			end
			S_NUM_B: begin
				nb_q <= xp_res;
			end
			default: begin
			end
		endcase
		if (stat_ld) begin
			stat_q <= stat_d;
		end
		if (out_ld) begin
			status_q  <= stat_q;
			vcount_q  <= count_q;
			oclosed_q <= closed_q;
		end
	end

endmodule

// File: design/simple_polygon_vertex_entry_core.sv
// channel | signals                            | handshake
// input   | op, point_x, point_y               | in_valid / in_stall
// output  | status, vertex_count, is_closed    | out_valid / out_stall
// config  | window_height                      | cfg_valid / cfg_ready
//
// Add and close with n stored vertices walk the stored edges in turn, each through
// S_FETCH, S_DET, S_NUM_A, S_NUM_B and S_CHECK, a pace set by the single RAM read
// port and the shared cross-product unit, which forms three determinants per edge.
// Reset empties and opens the polygon and loads window_height with 800; the vertex
// RAM is not cleared. A result waits in the output register under out_stall while
// the next word is accepted.
module simple_polygon_vertex_entry_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [spve_pkg::OP_W-1:0]     op,
	input  logic [spve_pkg::COORD_W-1:0]  point_x,
	input  logic [spve_pkg::COORD_W-1:0]  point_y,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [spve_pkg::STATUS_W-1:0] status,
	output logic [spve_pkg::CNT_W-1:0]    vertex_count,
	output logic                          is_closed,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [spve_pkg::COORD_W-1:0]  window_height
);

	import spve_pkg::*;

	logic [COORD_W-1:0]       win_h_q;
	logic                     idle;
	ram_req_t                 ram_req;
	logic [VTX_W-1:0]         ram_rdata;
	xp_op_t                   xp_op;
	logic signed [PROD_W-1:0] xp_res;

	assign cfg_ready = idle;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_h_q <= WIN_H_RESET;
		end else if (cfg_valid && cfg_ready) begin
			win_h_q <= window_height;
		end
	end

	spve_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.op           (op),
		.point_x      (point_x),
		.point_y      (point_y),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.vertex_count (vertex_count),
		.is_closed    (is_closed),
		.win_h        (win_h_q),
		.idle         (idle),
		.ram_req      (ram_req),
		.ram_rdata    (ram_rdata),
		.xp_op        (xp_op),
		.xp_res       (xp_res)
	);

	spve_ram #(
		.WIDTH (VTX_W),
		.DEPTH (MAX_VERTICES)
	) u_vtx_ram (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.re    (ram_req.re),
		.raddr (ram_req.raddr),
		.rdata (ram_rdata)
	);

	spve_xprod u_xprod (
		.xp_op  (xp_op),
		.xp_res (xp_res)
	);

endmodule

// File: design/spve_chk.sv
`include "simple_polygon_vertex_entry_core_assert.svh"

module spve_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [spve_pkg::STATUS_W-1:0] status,
	input logic [spve_pkg::CNT_W-1:0]    vertex_count,
	input logic                          is_closed
);

	import spve_pkg::*;

	`SPVE_ASSERT_NOW(a_count_bound, clk, arst_n, out_valid, vertex_count <= CNT_W'(MAX_VERTICES), "vertex count beyond capacity")

	`SPVE_ASSERT_NOW(a_closed_poly, clk, arst_n, out_valid && is_closed, vertex_count >= CNT_W'(MIN_POLY), "closed polygon with too few vertices")

	`SPVE_ASSERT_NOW(a_full_count, clk, arst_n, out_valid && (status == ST_FULL), vertex_count == CNT_W'(MAX_VERTICES), "full reported below capacity")

	`SPVE_ASSERT_NXT(a_busy_after_take, clk, arst_n, in_valid && !in_stall, in_stall, "second word taken while busy")

	`SPVE_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(status) && $stable(vertex_count) && $stable(is_closed), "stalled result changed")

endmodule

bind simple_polygon_vertex_entry_core spve_chk u_chk (.*);

// File: dv/tb_simple_polygon_vertex_entry_core.sv
`timescale 1ns / 1ps

module tb_simple_polygon_vertex_entry_core;
	import spve_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int STALL_LIMIT     = 2000;
	localparam int DRAIN_CYCLES    = 20;
	localparam int RANDOM_WORDS    = 760;
	localparam int MAX_REPORTS     = 10;

	typedef struct packed {
		status_t            st;
		logic [CNT_W-1:0]   cnt;
		logic               closed;
	} poly_result_t;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic [OP_W-1:0]     op;
	logic [COORD_W-1:0]  point_x;
	logic [COORD_W-1:0]  point_y;
	logic                out_valid;
	logic                out_stall;
	logic [STATUS_W-1:0] status;
	logic [CNT_W-1:0]    vertex_count;
	logic                is_closed;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [COORD_W-1:0]  window_height;

	// Predictor state
	logic [COORD_W-1:0] poly_x [MAX_VERTICES];
	logic [COORD_W-1:0] poly_y [MAX_VERTICES];
	int                 poly_cnt;
	bit                 poly_closed;
	logic [COORD_W-1:0] win_height;

	poly_result_t due_results [$];

	bit tx_no_idle;
	bit rx_no_idle;
	bit hold_off_req;
	int idle_cycles;
	int words_sent;
	int results_seen;
	int mismatches;
	int height_writes;
	int status_tally [5];

	simple_polygon_vertex_entry_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.op            (op),
		.point_x       (point_x),
		.point_y       (point_y),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.vertex_count  (vertex_count),
		.is_closed     (is_closed),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.window_height (window_height)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic bit between_open(input int n, input int d);
		if (d > 0)
			return n > 0 && n < d;
		return n < 0 && n > d;
	endfunction

	// True when segment (x1,y1)-(x2,y2) properly crosses any stored polyline segment
	function automatic bit edge_hits_store(input int x1, input int y1, input int x2,
			input int y2);
		int i;
		int dx12, dy12, dx34, dy34, a, b, d, na, nb;
		dx12 = x2 - x1;
		dy12 = y2 - y1;
		for (i = 0; i + 1 < poly_cnt; i++) begin
			dx34 = int'(poly_x[i + 1]) - int'(poly_x[i]);
			dy34 = int'(poly_y[i + 1]) - int'(poly_y[i]);
			a    = int'(poly_x[i]) - x1;
			b    = int'(poly_y[i]) - y1;
			d    = dx34 * dy12 - dx12 * dy34;
			na   = dx34 * b - a * dy34;
			nb   = dx12 * b - a * dy12;
			if (d != 0 && between_open(na, d) && between_open(nb, d))
				return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic poly_result_t apply_poly_op(input logic [OP_W-1:0] o,
			input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
		poly_result_t r;
		int fy;
		int lx, ly;
		r.st = ST_OK;
		lx = (poly_cnt > 0) ? int'(poly_x[poly_cnt - 1]) : 0;
		ly = (poly_cnt > 0) ? int'(poly_y[poly_cnt - 1]) : 0;
		case (o)
			OP_ADD: begin
				fy = int'(win_height) - int'(y);
				if (fy < 0)
					fy = 0;
				if (poly_closed)
					r.st = ST_CLOSED;
				else if (poly_cnt >= MAX_VERTICES)
					r.st = ST_FULL;
				else if (poly_cnt >= MIN_POLY && edge_hits_store(lx, ly, int'(x), fy))
					r.st = ST_CROSS;
				else begin
					poly_x[poly_cnt] = x;
					poly_y[poly_cnt] = COORD_W'(fy);
					poly_cnt++;
				end
			end
			OP_CLOSE: begin
				if (poly_cnt < MIN_POLY)
					r.st = ST_FEW;
				else if (edge_hits_store(lx, ly, int'(poly_x[0]), int'(poly_y[0])))
					r.st = ST_CROSS;
				else
					poly_closed = 1'b1;
			end
			OP_CLEAR: begin
				poly_cnt    = 0;
				poly_closed = 1'b0;
			end
			default: ;
		endcase
		r.cnt    = CNT_W'(poly_cnt);
		r.closed = poly_closed;
		return r;
	endfunction

	task automatic send_word(input logic [OP_W-1:0] o, input logic [COORD_W-1:0] x,
			input logic [COORD_W-1:0] y);
		int unsigned gap;
		gap = tx_no_idle ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		op       <= o;
		point_x  <= x;
		point_y  <= y;
		do @(posedge clk); while (in_stall);
		due_results.push_back(apply_poly_op(o, x, y));
		words_sent++;
	endtask

	// Add a point given in flipped coordinates; fy must not exceed the current height
	task automatic add_flipped(input int x, input int fy);
		send_word(OP_ADD, COORD_W'(x), COORD_W'(int'(win_height) - fy));
	endtask

	task automatic wait_drained();
		while (due_results.size() != 0) @(posedge clk);
	endtask

	task automatic load_height(input logic [COORD_W-1:0] h);
		in_valid <= 1'b0;
		wait_drained();
		cfg_valid     <= 1'b1;
		window_height <= h;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid  <= 1'b0;
		win_height = h;
		height_writes++;
	endtask

	task automatic test_empty_and_unused_op();
		send_word(OP_CLEAR, '0, '0);
		send_word(OP_CLOSE, '1, '1);
		send_word(OP_UNUSED, '1, '0);
	endtask

	task automatic test_extreme_points();
		send_word(OP_ADD, '0, '0);
		send_word(OP_ADD, '1, '1);  // y clamps at zero
		send_word(OP_CLOSE, '0, '0);
		send_word(OP_ADD, '1, '0);
		send_word(OP_ADD, '0, '1);
		send_word(OP_CLOSE, '0, '0);
	endtask

	task automatic test_crossing_rules();
		send_word(OP_CLEAR, '0, '0);
		add_flipped(100, 100);
		add_flipped(300, 100);
		add_flipped(300, 300);
		add_flipped(100, 300);
		add_flipped(200, 0);    // cuts the first segment
		add_flipped(200, 100);  // touches it only
		add_flipped(250, 100);  // runs along it, parallel
		send_word(OP_CLOSE, '0, '0);
		add_flipped(50, 50);    // refused while closed
		send_word(OP_CLOSE, '0, '0);
		// bow-tie: the closing segment cuts the second one
		send_word(OP_CLEAR, '0, '0);
		add_flipped(0, 0);
		add_flipped(100, 0);
		add_flipped(0, 100);
		add_flipped(100, 100);
		send_word(OP_CLOSE, '0, '0);
	endtask

	// Monotone x keeps every add clear of crossings, so the store fills
	task automatic test_full_store_under_backpressure();
		int i;
		send_word(OP_CLEAR, '0, '0);
		hold_off_req = 1'b1;
		for (i = 0; i < MAX_VERTICES; i++)
			send_word(OP_ADD, COORD_W'(i * 16 + $urandom_range(0, 15)),
				COORD_W'($urandom_range(0, 1023)));
		send_word(OP_ADD, COORD_W'($urandom_range(0, 1023)), COORD_W'($urandom_range(0, 1023)));
		send_word(OP_CLOSE, '0, '0);
		send_word(OP_ADD, '0, '0);
		send_word(OP_CLEAR, '0, '0);
	endtask

	task automatic run_random_shape();
		int n, k, extra, span, x0, y0;
		tx_no_idle = ($urandom_range(0, 4) == 0);
		rx_no_idle = ($urandom_range(0, 4) == 0);
		case ($urandom_range(0, 3))
			0: span = 15;
			1: span = 63;
			2: span = 255;
			default: span = 1023;
		endcase
		x0 = $urandom_range(0, 1023 - span);
		y0 = $urandom_range(0, 1023 - span);
		if ($urandom_range(0, 7) != 0)
			send_word(OP_CLEAR, '0, '0);
		n = ($urandom_range(0, 15) == 0) ? 70 : $urandom_range(1, 14);
		for (k = 0; k < n; k++) begin
			if ($urandom_range(0, 9) == 0)
				send_word(OP_W'($urandom_range(0, 3)), COORD_W'($urandom_range(0, 1023)),
					COORD_W'($urandom_range(0, 1023)));
			else
				send_word(OP_ADD, COORD_W'(x0 + $urandom_range(0, span)),
					COORD_W'(y0 + $urandom_range(0, span)));
		end
		send_word(OP_CLOSE, '0, '0);
		extra = $urandom_range(0, 2);
		for (k = 0; k < extra; k++)
			send_word($urandom_range(0, 1) ? OP_ADD : OP_CLOSE,
				COORD_W'(x0 + $urandom_range(0, span)), COORD_W'(y0 + $urandom_range(0, span)));
	endtask

	task automatic test_random_shapes(input int target);
		int phase, start;
		for (phase = 0; phase < 8; phase++) begin
			case (phase)
				0: load_height('1);
				1: load_height('0);
				7: load_height(COORD_W'(800));
				default: load_height(COORD_W'($urandom_range(0, 1023)));
			endcase
			start = words_sent;
			while (words_sent - start < (phase == 1 ? target / 32 : target / 7))
				run_random_shape();
		end
	endtask

	// Receiver: random hold-off per result, plus one long hold on request
	initial begin : result_sink
		int unsigned gap;
		out_stall <= 1'b1;
		do @(posedge clk); while (!arst_n);
		forever begin
			gap = rx_no_idle ? 0 : $urandom_range(0, 15);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				gap          = HOLD_OFF_CYCLES;
			end
			if (gap > 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	always @(posedge clk) begin : result_check
		poly_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (due_results.size() == 0) begin
				if (mismatches < MAX_REPORTS)
					$display("unexpected result %0d: status %0d count %0d closed %0b",
						results_seen, status, vertex_count, is_closed);
				mismatches++;
			end else begin
				want = due_results.pop_front();
				status_tally[int'(want.st)]++;
				if (status !== want.st || vertex_count !== want.cnt ||
						is_closed !== want.closed) begin
					if (mismatches < MAX_REPORTS)
						$display({"mismatch at result %0d: status exp %0d got %0d, ",
							"count exp %0d got %0d, closed exp %0b got %0b"},
							results_seen, want.st, status, want.cnt, vertex_count,
							want.closed, is_closed);
					mismatches++;
				end
			end
		end
	end

	// Watchdog: count cycles in which no word moves on any channel
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else if (idle_cycles >= STALL_LIMIT) begin
			$display("no progress for %0d cycles, %0d results outstanding", idle_cycles,
				due_results.size());
			$display("== FAIL ==");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		arst_n        <= 1'b0;
		in_valid      <= 1'b0;
		op            <= OP_ADD;
		point_x       <= '0;
		point_y       <= '0;
		cfg_valid     <= 1'b0;
		window_height <= WIN_H_RESET;
		poly_cnt      = 0;
		poly_closed   = 1'b0;
		win_height    = WIN_H_RESET;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_and_unused_op();
		test_extreme_points();
		test_crossing_rules();
		test_full_store_under_backpressure();
		test_random_shapes(RANDOM_WORDS);
		load_height(COORD_W'(1023 - $urandom_range(0, 3)));
		test_crossing_rules();

		in_valid <= 1'b0;
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d words sent, %0d results checked, %0d height writes, %0d mismatches",
			words_sent, results_seen, height_writes, mismatches);
		$display("outcomes: accepted %0d, crossing %0d, too few %0d, full %0d, closed %0d",
			status_tally[0], status_tally[1], status_tally[2], status_tally[3],
			status_tally[4]);
		if (mismatches == 0 && due_results.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
